@@ sv/ptd_pkg.sv @@
package ptd_pkg;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_CREATE = 3'd1,
    FN_KILL   = 3'd2,
    FN_PAUSE  = 3'd3,
    FN_RESUME = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    RS_READY     = 2'd0,
    RS_DORMANT   = 2'd1,
    RS_SUSPENDED = 2'd2
  } run_state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CREATE,
    WR_KILL,
    WR_PAUSE,
    WR_READY,
    WR_COUNT
  } wr_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_RMATCH,
    ST_RPASS,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    wr_op_t      op;
    logic [2:0]  idx;
    logic [7:0]  name;
    logic [15:0] period;
    logic [15:0] count;
  } tbl_wr_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  name;
    logic [15:0] period;
    logic [15:0] countdown;
    run_state_t  rs;
  } slot_ent_t;

  typedef struct packed {
    logic can_emit;
    logic pending;
    logic out_free;
  } buf_stat_t;

endpackage

@@ sv/periodic_task_dispatcher_core.sv @@
// Time-triggered task dispatcher with NUM_SLOTS priority-ordered slots. A create item
// is written from idle and leaves the block ready for the next item. Tick, kill and
// pause walk the slot table one slot per cycle through its single read port, a tick
// walk only while a due dispatch can be emitted; resume checks one slot per cycle and
// runs a full tick walk, held the same way, after each name match. Each dispatch is one
// result item; the last result of an item carries out_last. A stalled output holds a
// walk when a dispatch is ready while a result still waits in the output register,
// since one result is held back until the block knows whether it is the final one.
module periodic_task_dispatcher_core #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [2:0]  in_slot,
  input  logic [7:0]  in_task_name,
  input  logic [15:0] in_period,
  input  logic [7:0]  in_first_delay,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_dispatch_slot,
  output logic [7:0]  out_dispatch_name,
  output logic        out_last
);

  localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [IDXW-1:0]     rd_idx;
  ptd_pkg::slot_ent_t  rd_ent;
  ptd_pkg::tbl_wr_t    wr;
  ptd_pkg::buf_stat_t  stat;
  logic                emit;
  logic [2:0]          emit_slot;
  logic [7:0]          emit_name;
  logic                flush;

  ptd_slot_table #(.NUM_SLOTS(NUM_SLOTS)) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd_ent (rd_ent),
    .wr     (wr)
  );

  ptd_seq #(.NUM_SLOTS(NUM_SLOTS)) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_task_name   (in_task_name),
    .in_period      (in_period),
    .in_first_delay (in_first_delay),
    .rd_idx         (rd_idx),
    .rd_ent         (rd_ent),
    .wr             (wr),
    .stat           (stat),
    .emit           (emit),
    .emit_slot      (emit_slot),
    .emit_name      (emit_name),
    .flush          (flush)
  );

  ptd_out_buf u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .emit              (emit),
    .emit_slot         (emit_slot),
    .emit_name         (emit_name),
    .flush             (flush),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_dispatch_slot (out_dispatch_slot),
    .out_dispatch_name (out_dispatch_name),
    .out_last          (out_last)
  );

endmodule

@@ sv/ptd_slot_table.sv @@
module ptd_slot_table #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_idx,
  output ptd_pkg::slot_ent_t                      rd_ent,
  input  ptd_pkg::tbl_wr_t                        wr
);

  localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic                 active_r [NUM_SLOTS];
  logic [7:0]           name_r   [NUM_SLOTS];
  logic [15:0]          period_r [NUM_SLOTS];
  logic [15:0]          count_r  [NUM_SLOTS];
  ptd_pkg::run_state_t  rs_r     [NUM_SLOTS];
  logic [IDXW-1:0]      widx;

  assign widx = wr.idx[IDXW-1:0];

  always_comb begin
    rd_ent.active    = active_r[rd_idx];
    rd_ent.name      = name_r[rd_idx];
    rd_ent.period    = period_r[rd_idx];
    rd_ent.countdown = count_r[rd_idx];
    rd_ent.rs        = rs_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        active_r[k] <= 1'b0;
        name_r[k]   <= '0;
        period_r[k] <= '0;
        count_r[k]  <= '0;
        rs_r[k]     <= ptd_pkg::RS_READY;
      end
    end else begin
      case (wr.op)
        ptd_pkg::WR_CREATE: begin
          active_r[widx] <= 1'b1;
          name_r[widx]   <= wr.name;
          period_r[widx] <= wr.period;
          count_r[widx]  <= wr.count;
          rs_r[widx]     <= ptd_pkg::RS_READY;
        end
        ptd_pkg::WR_KILL: begin
          active_r[widx] <= 1'b0;
          name_r[widx]   <= '0;
          period_r[widx] <= '0;
        end
        ptd_pkg::WR_PAUSE: begin
          rs_r[widx] <= ptd_pkg::RS_SUSPENDED;
        end
        ptd_pkg::WR_READY: begin
          rs_r[widx] <= ptd_pkg::RS_READY;
        end
        ptd_pkg::WR_COUNT: begin
          count_r[widx] <= wr.count;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/ptd_out_buf.sv @@
module ptd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                emit,
  input  logic [2:0]          emit_slot,
  input  logic [7:0]          emit_name,
  input  logic                flush,
  output ptd_pkg::buf_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_dispatch_slot,
  output logic [7:0]          out_dispatch_name,
  output logic                out_last
);

  logic       pv_r, pv_nxt;
  logic [2:0] ps_r, ps_nxt;
  logic [7:0] pn_r, pn_nxt;
  logic       ov_r, ov_nxt;
  logic [2:0] os_r, os_nxt;
  logic [7:0] on_r, on_nxt;
  logic       ol_r, ol_nxt;
  logic       out_free;
  logic       load;

  assign out_free      = !ov_r || !out_stall;
  assign stat.out_free = out_free;
  assign stat.pending  = pv_r;
  assign stat.can_emit = !pv_r || out_free;

  always_comb begin
    pv_nxt = pv_r;
    ps_nxt = ps_r;
    pn_nxt = pn_r;
    os_nxt = os_r;
    on_nxt = on_r;
    ol_nxt = ol_r;
    load   = 1'b0;
    if (emit) begin
      if (pv_r) begin
        load   = 1'b1;
        os_nxt = ps_r;
        on_nxt = pn_r;
        ol_nxt = 1'b0;
      end
      pv_nxt = 1'b1;
      ps_nxt = emit_slot;
      pn_nxt = emit_name;
    end else if (flush && pv_r && out_free) begin
      load   = 1'b1;
      os_nxt = ps_r;
      on_nxt = pn_r;
      ol_nxt = 1'b1;
      pv_nxt = 1'b0;
    end
    ov_nxt = load || (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
      ov_r <= ov_nxt;
    end
    ps_r <= ps_nxt;
    pn_r <= pn_nxt;
    os_r <= os_nxt;
    on_r <= on_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid         = ov_r;
  assign out_dispatch_slot = os_r;
  assign out_dispatch_name = on_r;
  assign out_last          = ol_r;

endmodule

@@ sv/ptd_seq.sv @@
module ptd_seq #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [2:0]                              in_func,
  input  logic [2:0]                              in_slot,
  input  logic [7:0]                              in_task_name,
  input  logic [15:0]                             in_period,
  input  logic [7:0]                              in_first_delay,
  output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_idx,
  input  ptd_pkg::slot_ent_t                      rd_ent,
  output ptd_pkg::tbl_wr_t                        wr,
  input  ptd_pkg::buf_stat_t                      stat,
  output logic                                    emit,
  output logic [2:0]                              emit_slot,
  output logic [7:0]                              emit_name,
  output logic                                    flush
);

  localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_SLOTS - 1);

  ptd_pkg::seq_state_t state_r, state_nxt;
  ptd_pkg::func_t      mode_r, mode_nxt;
  logic [7:0]          name_r, name_nxt;
  logic [IDXW-1:0]     idx_r, idx_nxt;
  logic [IDXW-1:0]     oidx_r, oidx_nxt;

  ptd_pkg::func_t      func_in;
  logic                match;
  logic                runnable;
  logic                zero;
  logic [15:0]         sub_opd;
  logic [15:0]         sub_res;
  logic                step_hold;

  assign func_in  = ptd_pkg::func_t'(in_func);
  assign rd_idx   = (state_r == ptd_pkg::ST_RMATCH) ? oidx_r : idx_r;
  assign match    = (rd_ent.name == name_r);
  assign runnable = rd_ent.active &&
                    (rd_ent.rs inside {ptd_pkg::RS_READY, ptd_pkg::RS_DORMANT});
  assign zero     = (rd_ent.countdown == 16'd0);

  // One decrementer serves both the reload and the countdown.
  assign sub_opd   = zero ? rd_ent.period : rd_ent.countdown;
  assign sub_res   = sub_opd - 16'd1;
  assign step_hold = runnable && zero && !stat.can_emit;

  assign emit_slot = 3'(rd_idx);
  assign emit_name = rd_ent.name;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    name_nxt  = name_r;
    idx_nxt   = idx_r;
    oidx_nxt  = oidx_r;
    wr.op     = ptd_pkg::WR_NONE;
    wr.idx    = 3'(rd_idx);
    wr.name   = name_r;
    wr.period = '0;
    wr.count  = sub_res;
    emit      = 1'b0;
    flush     = 1'b0;
    in_stall  = (state_r != ptd_pkg::ST_IDLE);
    case (state_r)
      ptd_pkg::ST_IDLE: begin
        if (in_valid) begin
          name_nxt = in_task_name;
          mode_nxt = func_in;
          idx_nxt  = '0;
          oidx_nxt = '0;
          case (func_in)
            ptd_pkg::FN_TICK, ptd_pkg::FN_KILL, ptd_pkg::FN_PAUSE: begin
              state_nxt = ptd_pkg::ST_WALK;
            end
            ptd_pkg::FN_RESUME: begin
              state_nxt = ptd_pkg::ST_RMATCH;
            end
            ptd_pkg::FN_CREATE: begin
              if ({1'b0, in_slot} < 4'(NUM_SLOTS)) begin
                wr.op     = ptd_pkg::WR_CREATE;
                wr.idx    = in_slot;
                wr.name   = in_task_name;
                wr.period = in_period;
                wr.count  = {8'd0, in_first_delay};
              end
            end
            default: begin
            end
          endcase
        end
      end
      ptd_pkg::ST_WALK: begin
        case (mode_r)
          ptd_pkg::FN_KILL: begin
            if (match) wr.op = ptd_pkg::WR_KILL;
          end
          ptd_pkg::FN_PAUSE: begin
            if (match) wr.op = ptd_pkg::WR_PAUSE;
          end
          default: begin
            if (runnable && !step_hold) begin
              wr.op = ptd_pkg::WR_COUNT;
              emit  = zero;
            end
          end
        endcase
        if (!((mode_r == ptd_pkg::FN_TICK) && step_hold)) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = ptd_pkg::ST_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ptd_pkg::ST_RMATCH: begin
        if (match) begin
          wr.op     = ptd_pkg::WR_READY;
          idx_nxt   = '0;
          state_nxt = ptd_pkg::ST_RPASS;
        end else if (oidx_r == LAST_IDX) begin
          state_nxt = ptd_pkg::ST_FIN;
        end else begin
          oidx_nxt = oidx_r + 1'b1;
        end
      end
      ptd_pkg::ST_RPASS: begin
        if (runnable && !step_hold) begin
          wr.op = ptd_pkg::WR_COUNT;
          emit  = zero;
        end
        if (!step_hold) begin
          if (idx_r != LAST_IDX) begin
            idx_nxt = idx_r + 1'b1;
          end else if (oidx_r == LAST_IDX) begin
            state_nxt = ptd_pkg::ST_FIN;
          end else begin
            oidx_nxt  = oidx_r + 1'b1;
            state_nxt = ptd_pkg::ST_RMATCH;
          end
        end
      end
      ptd_pkg::ST_FIN: begin
        flush = 1'b1;
        if (!stat.pending || stat.out_free) state_nxt = ptd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ptd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptd_pkg::ST_IDLE;
      idx_r   <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      oidx_r  <= oidx_nxt;
    end
    mode_r <= mode_nxt;
    name_r <= name_nxt;
  end

endmodule

@@ sv/ptd_checker.sv @@
module ptd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] in_func,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_dispatch_slot,
  input logic [7:0] out_dispatch_name,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dispatch_slot) &&
      $stable(out_dispatch_name) && $stable(out_last))
    else $error("stalled result item changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == ptd_pkg::FN_TICK) |=> in_stall)
    else $error("tick item did not occupy the block");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("block took an item while results of the last one remain");

endmodule

bind periodic_task_dispatcher_core ptd_checker u_ptd_checker (.*);

@@ tb/periodic_task_dispatcher_core_test.sv @@
`timescale 1ns / 1ps

module periodic_task_dispatcher_core_test;

  localparam int SLOTS = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [2:0] FN_SPARE_A = 3'd5;
  localparam logic [2:0] FN_SPARE_B = 3'd6;
  localparam logic [2:0] FN_SPARE_C = 3'd7;

  typedef struct packed {
    logic [2:0] slot;
    logic [7:0] name;
    logic       last;
  } dispatch_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [2:0]  in_slot;
  logic [7:0]  in_task_name;
  logic [15:0] in_period;
  logic [7:0]  in_first_delay;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_dispatch_slot;
  logic [7:0]  out_dispatch_name;
  logic        out_last;

  logic                tbl_active [SLOTS];
  logic [7:0]          tbl_name [SLOTS];
  logic [15:0]         tbl_period [SLOTS];
  logic [15:0]         tbl_count [SLOTS];
  ptd_pkg::run_state_t tbl_rs [SLOTS];

  dispatch_t pending_dispatches[$];
  dispatch_t walk_dispatches[$];
  dispatch_t want;
  int        fail_count = 0;
  int        out_gap = 0;
  int        idle_cycles = 0;
  bit        gaps_on = 1'b1;

  periodic_task_dispatcher_core #(
    .NUM_SLOTS(SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_slot(in_slot),
    .in_task_name(in_task_name),
    .in_period(in_period),
    .in_first_delay(in_first_delay),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_dispatch_slot(out_dispatch_slot),
    .out_dispatch_name(out_dispatch_name),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic clear_table();
    for (int k = 0; k < SLOTS; k++) begin
      tbl_active[k] = 1'b0;
      tbl_name[k] = 8'd0;
      tbl_period[k] = 16'd0;
      tbl_count[k] = 16'd0;
      tbl_rs[k] = ptd_pkg::RS_READY;
    end
  endtask

  task automatic tick_walk();
    for (int k = 0; k < SLOTS; k++) begin
      if (tbl_active[k] &&
          (tbl_rs[k] == ptd_pkg::RS_READY || tbl_rs[k] == ptd_pkg::RS_DORMANT)) begin
        if (tbl_count[k] == 16'd0) begin
          tbl_count[k] = tbl_period[k] - 16'd1;
          walk_dispatches.push_back({3'(k), tbl_name[k], 1'b0});
        end else begin
          tbl_count[k] = tbl_count[k] - 16'd1;
        end
      end
    end
  endtask

  task automatic predict_dispatches(logic [2:0] func, logic [2:0] slot, logic [7:0] name,
                                    logic [15:0] period, logic [7:0] delay);
    walk_dispatches.delete();
    case (func)
      ptd_pkg::FN_TICK: begin
        tick_walk();
      end
      ptd_pkg::FN_CREATE: begin
        if (slot < SLOTS) begin
          tbl_active[slot] = 1'b1;
          tbl_name[slot] = name;
          tbl_period[slot] = period;
          tbl_count[slot] = {8'd0, delay};
          tbl_rs[slot] = ptd_pkg::RS_READY;
        end
      end
      ptd_pkg::FN_KILL: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (tbl_name[k] == name) begin
            tbl_name[k] = 8'd0;
            tbl_period[k] = 16'd0;
            tbl_active[k] = 1'b0;
          end
        end
      end
      ptd_pkg::FN_PAUSE: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (tbl_name[k] == name) tbl_rs[k] = ptd_pkg::RS_SUSPENDED;
        end
      end
      ptd_pkg::FN_RESUME: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (tbl_name[k] == name) begin
            tbl_rs[k] = ptd_pkg::RS_READY;
            tick_walk();
          end
        end
      end
      default: begin
      end
    endcase
    if (walk_dispatches.size() > 0) walk_dispatches[$].last = 1'b1;
    foreach (walk_dispatches[i]) pending_dispatches.push_back(walk_dispatches[i]);
  endtask

  task automatic send_item(logic [2:0] func, logic [2:0] slot, logic [7:0] name,
                           logic [15:0] period, logic [7:0] delay);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_func = func;
    in_slot = slot;
    in_task_name = name;
    in_period = period;
    in_first_delay = delay;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_dispatches(func, slot, name, period, delay);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_stall = 1'b1;
      out_gap = out_gap - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_dispatches.size() == 0) begin
        $error("unexpected item: dispatch_slot %0d dispatch_name %0d last %0d",
               out_dispatch_slot, out_dispatch_name, out_last);
        fail_count++;
      end else begin
        want = pending_dispatches.pop_front();
        if (out_dispatch_slot !== want.slot) begin
          $error("dispatch_slot: expected %0d, got %0d", want.slot, out_dispatch_slot);
          fail_count++;
        end
        if (out_dispatch_name !== want.name) begin
          $error("dispatch_name: expected %0d, got %0d", want.name, out_dispatch_name);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          fail_count++;
        end
      end
      out_gap = gaps_on ? $urandom_range(0, 9) : 0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** periodic_task_dispatcher_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic test_full_resume();
    for (int k = 0; k < SLOTS; k++) send_item(ptd_pkg::FN_CREATE, 3'(k), 8'd0, 16'd1, 8'd0);
    send_item(ptd_pkg::FN_RESUME, 3'd0, 8'd0, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_TICK, 3'd0, 8'd0, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_KILL, 3'd0, 8'd0, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_TICK, 3'd0, 8'd0, 16'd0, 8'd0);
  endtask

  task automatic test_field_extremes();
    send_item(ptd_pkg::FN_CREATE, 3'd7, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(ptd_pkg::FN_CREATE, 3'd3, 8'hAA, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_CREATE, 3'd0, 8'h5A, 16'd2, 8'd1);
    send_item(ptd_pkg::FN_TICK, 3'd0, 8'd0, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_TICK, 3'd7, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(ptd_pkg::FN_PAUSE, 3'd0, 8'hAA, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_TICK, 3'd0, 8'd0, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_RESUME, 3'd0, 8'hAA, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_KILL, 3'd0, 8'h77, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_KILL, 3'd0, 8'hFF, 16'd0, 8'd0);
    send_item(ptd_pkg::FN_TICK, 3'd0, 8'd0, 16'd0, 8'd0);
    send_item(FN_SPARE_A, 3'd7, 8'h5A, 16'd1, 8'd0);
    send_item(FN_SPARE_B, 3'd0, 8'hAA, 16'd0, 8'd0);
    send_item(FN_SPARE_C, 3'd7, 8'hFF, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_random_traffic(int n_items);
    logic [2:0]  func;
    logic [2:0]  slot;
    logic [7:0]  name;
    logic [15:0] period;
    logic [7:0]  delay;
    int          pick;
    int          shape;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      slot = 3'($urandom);
      period = 16'($urandom);
      delay = 8'($urandom);
      name = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 4)) : 8'($urandom);
      if (pick < 45) begin
        func = ptd_pkg::FN_TICK;
      end else if (pick < 65) begin
        func = ptd_pkg::FN_CREATE;
        shape = $urandom_range(0, 19);
        if (shape < 14) period = 16'($urandom_range(1, 6));
        else if (shape < 16) period = 16'd0;
        else if (shape < 18) period = 16'hFFFF;
        if ($urandom_range(0, 9) < 8) delay = 8'($urandom_range(0, 3));
      end else if (pick < 73) begin
        func = ptd_pkg::FN_KILL;
      end else if (pick < 81) begin
        func = ptd_pkg::FN_PAUSE;
      end else if (pick < 95) begin
        func = ptd_pkg::FN_RESUME;
      end else begin
        func = 3'($urandom_range(FN_SPARE_A, FN_SPARE_C));
      end
      send_item(func, slot, name, period, delay);
    end
  endtask

  task automatic test_back_to_back(int n_items);
    gaps_on = 1'b0;
    test_random_traffic(n_items);
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = ptd_pkg::FN_TICK;
    in_slot = 3'd0;
    in_task_name = 8'd0;
    in_period = 16'd0;
    in_first_delay = 8'd0;
    clear_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_full_resume();
    test_field_extremes();
    test_random_traffic(200);
    test_back_to_back(120);
    test_random_traffic(90);
    in_valid = 1'b0;
    while (pending_dispatches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** periodic_task_dispatcher_core: PASSED **");
    end else begin
      $display("** periodic_task_dispatcher_core: FAILED **");
    end
    $finish;
  end

endmodule
